FILE: hdl/owrb_pkg.sv
package owrb_pkg;

  localparam int DEPTH_DEF       = 64;
  localparam int HANDLE_BITS_DEF = 16;
  localparam int VAL_BITS        = 16;
  localparam int CNT_BITS        = 7;
  localparam int CAP_RST_MAX     = 64;
  localparam int PADDR_BITS      = 3;
  localparam int PDATA_BITS      = 32;

  // register index, taken from the top address bit
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    OP_ENQ = 2'd0,
    OP_DEQ = 2'd1,
    OP_REM = 2'd2,
    OP_CLR = 2'd3
  } op_e;

  typedef struct packed {
    op_e                 opcode;
    logic [VAL_BITS-1:0] value_in;
  } in_item_t;

  typedef struct packed {
    logic                ok;
    logic [VAL_BITS-1:0] value_out;
    logic                overwrote;
    logic [CNT_BITS-1:0] count_after;
  } out_item_t;

  typedef struct packed {
    logic latch;
    logic enq;
    logic fail;
    logic deq_rd;
    logic deq;
    logic scan_start;
    logic scan_step;
    logic rm;
    logic clr;
    logic sweep;
    logic res_load;
  } owrb_cmd_t;

  typedef struct packed {
    op_e  op;
    logic hdl_zero;
    logic cnt_zero;
    logic scan_hit;
    logic scan_pend;
    logic scan_more;
    logic swp_last;
    logic out_free;
  } owrb_sts_t;

endpackage

FILE: hdl/overwriting_ring_buffer_with_removal.sv
// Ring of nonzero handles with overwrite of the oldest entry when full.
// Input beat: opcode (enqueue, dequeue, remove by match, clear) and a handle;
// every input beat not cut short by a capacity write yields exactly one
// output beat with ok, the dequeued handle, the overwrite flag and the
// entry count after the operation. Both channels use valid/stall; one item
// is in work at a time, and the next one is taken while the previous result
// still waits on a stall. Enqueue and rejected ops pass execute and result;
// dequeue adds a RAM read; remove reads one RAM word per slot, compare
// pipelined behind it; clear zeroes one RAM word a cycle up to the capacity.
// Entries sit in a single-port-write, registered-read RAM.
// After reset and after each APB write of the capacity register (top address
// bit clear), the ring empties and RAM words up to the capacity (DEPTH, at
// most 64, after reset) are zeroed, one word per cycle; input stalls meanwhile.
// A stalled output beat holds; the block finishes its current item and
// waits with the next result until the output register frees.
module overwriting_ring_buffer_with_removal import owrb_pkg::*; #(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [PDATA_BITS-1:0] pwdata,
  output logic [PDATA_BITS-1:0] prdata,
  output logic                  pready
);

  logic                cfg_we;
  logic [CNT_BITS-1:0] cap;
  owrb_cmd_t           cmd;
  owrb_sts_t           sts;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & (paddr[PADDR_BITS-1] == REG_CAPACITY);
  assign prdata = (paddr[PADDR_BITS-1] == REG_CAPACITY) ? PDATA_BITS'(cap) : '0;

  owrb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cfg_we_i   (cfg_we),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  owrb_dpath #(
    .DEPTH       (DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (pwdata[CNT_BITS-1:0]),
    .cap_o       (cap),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: hdl/owrb_ram.sv
module owrb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/owrb_dpath.sv
module owrb_dpath import owrb_pkg::*; #(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  in_item_t            in_data_i,
  input  logic                cfg_we_i,
  input  logic [CNT_BITS-1:0] cfg_wdata_i,
  output logic [CNT_BITS-1:0] cap_o,
  input  owrb_cmd_t           cmd_i,
  output owrb_sts_t           sts_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_data_o
);

  localparam int HW = (HANDLE_BITS < VAL_BITS) ? HANDLE_BITS : VAL_BITS;
  localparam int AW = $clog2(DEPTH);
  localparam logic [CNT_BITS-1:0] CAP_LIM =
    (DEPTH < 2**CNT_BITS) ? CNT_BITS'(DEPTH) : {CNT_BITS{1'b1}};
  localparam logic [CNT_BITS-1:0] CAP_RST =
    (DEPTH < CAP_RST_MAX) ? CNT_BITS'(DEPTH) : CNT_BITS'(CAP_RST_MAX);

  function automatic logic [CNT_BITS-1:0] wrap_inc(logic [CNT_BITS-1:0] p,
                                                   logic [CNT_BITS-1:0] cap);
    logic [CNT_BITS:0] n;
    n = {1'b0, p} + 1'b1;
    return (n >= {1'b0, cap}) ? '0 : n[CNT_BITS-1:0];
  endfunction

  logic [CNT_BITS-1:0] cap_q, head_q, tail_q, cnt_q, swp_q, iss_q, scan_q, rd_ptr_q;
  logic                pend_q, out_valid_q;
  op_e                 op_q;
  logic [HW-1:0]       hdl_q;
  logic                res_ok_q, res_ovw_q;
  logic [HW-1:0]       res_vout_q;
  out_item_t           out_q;
  logic [CNT_BITS-1:0] cap_wr;
  logic                full, scan_more;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [HW-1:0] ram_wdata, ram_rdata;

  assign full      = (cnt_q >= cap_q);
  assign scan_more = (iss_q != cnt_q);

  always_comb begin
    cap_wr = cfg_wdata_i;
    if (cap_wr == '0) begin
      cap_wr = CNT_BITS'(1);
    end
    if (cap_wr > CAP_LIM) begin
      cap_wr = CAP_LIM;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RST;
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      swp_q       <= '0;
      iss_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q  <= cap_wr;
        head_q <= '0;
        tail_q <= '0;
        cnt_q  <= '0;
        swp_q  <= '0;
      end else begin
        if (cmd_i.enq) begin
          tail_q <= wrap_inc(tail_q, cap_q);
          if (full) begin
            head_q <= wrap_inc(head_q, cap_q);
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        if (cmd_i.deq) begin
          head_q <= wrap_inc(head_q, cap_q);
          cnt_q  <= cnt_q - 1'b1;
        end
        if (cmd_i.clr) begin
          head_q <= '0;
          tail_q <= '0;
          cnt_q  <= '0;
          swp_q  <= '0;
        end
        if (cmd_i.sweep) begin
          swp_q <= swp_q + 1'b1;
        end
        if (cmd_i.scan_start) begin
          iss_q  <= '0;
          pend_q <= 1'b0;
        end
        if (cmd_i.scan_step) begin
          pend_q <= scan_more;
          if (scan_more) begin
            iss_q <= iss_q + 1'b1;
          end
        end
      end
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q  <= in_data_i.opcode;
      hdl_q <= in_data_i.value_in[HW-1:0];
    end
    if (cmd_i.enq) begin
      res_ok_q   <= 1'b1;
      res_vout_q <= '0;
      res_ovw_q  <= full;
    end
    if (cmd_i.fail) begin
      res_ok_q   <= 1'b0;
      res_vout_q <= '0;
      res_ovw_q  <= 1'b0;
    end
    if (cmd_i.deq) begin
      res_ok_q   <= 1'b1;
      res_vout_q <= ram_rdata;
      res_ovw_q  <= 1'b0;
    end
    if (cmd_i.rm || cmd_i.clr) begin
      res_ok_q   <= 1'b1;
      res_vout_q <= '0;
      res_ovw_q  <= 1'b0;
    end
    if (cmd_i.scan_start) begin
      scan_q <= head_q;
    end
    if (cmd_i.scan_step) begin
      rd_ptr_q <= scan_q;
      if (scan_more) begin
        scan_q <= wrap_inc(scan_q, cap_q);
      end
    end
    if (cmd_i.res_load) begin
      out_q.ok          <= res_ok_q;
      out_q.value_out   <= VAL_BITS'(res_vout_q);
      out_q.overwrote   <= res_ovw_q;
      out_q.count_after <= cnt_q;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    if (cmd_i.enq) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(tail_q);
      ram_wdata = hdl_q;
    end else if (cmd_i.deq) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(head_q);
    end else if (cmd_i.rm) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(rd_ptr_q);
    end else if (cmd_i.sweep) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(swp_q);
    end
    ram_re    = cmd_i.deq_rd | (cmd_i.scan_step & scan_more);
    ram_raddr = cmd_i.deq_rd ? AW'(head_q) : AW'(scan_q);
  end

  owrb_ram #(
    .WIDTH (HW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    sts_o.op        = op_q;
    sts_o.hdl_zero  = (hdl_q == '0);
    sts_o.cnt_zero  = (cnt_q == '0);
    sts_o.scan_hit  = pend_q && (ram_rdata == hdl_q);
    sts_o.scan_pend = pend_q;
    sts_o.scan_more = scan_more;
    sts_o.swp_last  = (swp_q == cap_q - 1'b1);
    sts_o.out_free  = !out_valid_q || !out_stall_i;
  end

  assign cap_o       = cap_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_cnt_le_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= cap_q)
    else $error("entry count above capacity");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q < cap_q) && (tail_q < cap_q))
    else $error("ring pointer out of range");

  a_ptr_meet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == cap_q) |-> (head_q == tail_q))
    else $error("head and tail disagree on empty or full ring");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.res_load |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over an untaken beat");

endmodule

FILE: hdl/owrb_ctrl.sv
module owrb_ctrl import owrb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  logic      cfg_we_i,
  input  owrb_sts_t sts_i,
  output owrb_cmd_t cmd_o
);

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_DEQ  = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_CLR  = 3'd5;
  localparam logic [2:0] S_RES  = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_INIT: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.swp_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall_o = cfg_we_i;
        if (in_valid_i && !cfg_we_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_RES;
        unique case (sts_i.op)
          OP_ENQ: begin
            if (sts_i.hdl_zero) begin
              cmd_o.fail = 1'b1;
            end else begin
              cmd_o.enq = 1'b1;
            end
          end
          OP_DEQ: begin
            if (sts_i.cnt_zero) begin
              cmd_o.fail = 1'b1;
            end else begin
              cmd_o.deq_rd = 1'b1;
              state_d      = S_DEQ;
            end
          end
          OP_REM: begin
            if (sts_i.cnt_zero || sts_i.hdl_zero) begin
              cmd_o.fail = 1'b1;
            end else begin
              cmd_o.scan_start = 1'b1;
              state_d          = S_SCAN;
            end
          end
          OP_CLR: begin
            cmd_o.clr = 1'b1;
            state_d   = S_CLR;
          end
        endcase
      end
      S_DEQ: begin
        cmd_o.deq = 1'b1;
        state_d   = S_RES;
      end
      S_SCAN: begin
        if (sts_i.scan_hit) begin
          cmd_o.rm = 1'b1;
          state_d  = S_RES;
        end else begin
          cmd_o.scan_step = 1'b1;
          if (!sts_i.scan_more && !sts_i.scan_pend) begin
            cmd_o.fail = 1'b1;
            state_d    = S_RES;
          end
        end
      end
      S_CLR: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.swp_last) begin
          state_d = S_RES;
        end
      end
      S_RES: begin
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
    if (cfg_we_i) begin
      state_d = S_INIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
